>>> hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, command codes and pipeline control types of the complex
// arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cau_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CMD_W          = 4;
   localparam int TOL_W          = 16;

   localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 4'd0,
      CMD_SUB   = 4'd1,
      CMD_MUL   = 4'd2,
      CMD_DIV   = 4'd3,
      CMD_NEG   = 4'd4,
      CMD_CONJ  = 4'd5,
      CMD_RECIP = 4'd6,
      CMD_MOD   = 4'd7,
      CMD_EQUAL = 4'd8
   } cmd_type;

   // control that travels with each item down the pipeline
   typedef struct packed {
      logic    vld;
      cmd_type cmd;
      logic    eq;
      logic    sat;
      logic    dz;
      logic    ovf_re;
      logic    ovf_im;
      logic    neg_re;
      logic    neg_im;
   } ctl_type;

   // operand signs after operand selection
   typedef struct packed {
      logic xr;
      logic xi;
      logic yr;
      logic yi;
   } sgn_type;

endpackage

>>> hw/rtl/cau_req_if.sv
// ----------------------------------------------------------------------------
// cau_req_if
// Request channel: command and two complex operands, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cau_req_if #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) ();
   import cau_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [CMD_W-1:0]             cmd;
   logic signed [DATA_WIDTH-1:0] a_re;
   logic signed [DATA_WIDTH-1:0] a_im;
   logic signed [DATA_WIDTH-1:0] b_re;
   logic signed [DATA_WIDTH-1:0] b_im;

   modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);

endinterface

>>> hw/rtl/cau_rsp_if.sv
// ----------------------------------------------------------------------------
// cau_rsp_if
// Response channel: complex result and status flags, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cau_rsp_if #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) ();

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] res_re;
   logic signed [DATA_WIDTH-1:0] res_im;
   logic                         is_equal;
   logic                         div_zero;
   logic                         saturated;

   modport source (output valid, res_re, res_im, is_equal, div_zero, saturated,
                   input ready);
   modport sink   (input valid, res_re, res_im, is_equal, div_zero, saturated,
                   output ready);

endinterface

>>> hw/rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// First stage: add, sub, neg, conj and equal finished here; operands for the
// multiplier array selected and turned into sign and magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_front #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_vld,
   input  logic [cau_pkg::CMD_W-1:0]    cmd,
   input  logic signed [DATA_WIDTH-1:0] a_re,
   input  logic signed [DATA_WIDTH-1:0] a_im,
   input  logic signed [DATA_WIDTH-1:0] b_re,
   input  logic signed [DATA_WIDTH-1:0] b_im,
   input  logic [cau_pkg::TOL_W-1:0]    tol,
   output cau_pkg::ctl_type             ctl,
   output logic signed [DATA_WIDTH-1:0] re,
   output logic signed [DATA_WIDTH-1:0] im,
   output logic [DATA_WIDTH-1:0]        xr_m,
   output logic [DATA_WIDTH-1:0]        xi_m,
   output logic [DATA_WIDTH-1:0]        yr_m,
   output logic [DATA_WIDTH-1:0]        yi_m,
   output cau_pkg::sgn_type             sgn
);
   import cau_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   // clip a W+1 bit value to W bits; top bit of the result flags clipping
   function automatic logic [W:0] clip(input logic signed [W:0] v);
      logic [W:0] r;
      if (v[W] != v[W-1]) begin
         r = {1'b1, (v[W] ? SMIN : SMAX)};
      end else begin
         r = {1'b0, v[W-1:0]};
      end
      return r;
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      logic [W-1:0] r;
      r = v[W-1] ? -v : v;
      return r;
   endfunction

   logic signed [W:0] ar, ai, br, bi;
   logic signed [W:0] de_re, de_im, tl, ntl;
   logic [W:0]        k_re, k_im;
   ctl_type           ctl_in, ctl_ff;
   logic [W-1:0]      xr_in, xi_in, yr_in, yi_in;
   logic [W-1:0]      xr_ff, xi_ff, yr_ff, yi_ff;
   logic signed [W-1:0] re_ff, im_ff;
   sgn_type           sgn_in, sgn_ff;

   assign ar    = {a_re[W-1], a_re};
   assign ai    = {a_im[W-1], a_im};
   assign br    = {b_re[W-1], b_re};
   assign bi    = {b_im[W-1], b_im};
   assign de_re = ar - br;
   assign de_im = ai - bi;
   assign tl    = signed'({{(W+1-TOL_W){1'b0}}, tol});
   assign ntl   = -tl;

   // short commands
   always_comb begin
      ctl_in     = '0;
      ctl_in.vld = in_vld;
      ctl_in.cmd = cmd_type'(cmd);
      k_re       = '0;
      k_im       = '0;
      case (cmd_type'(cmd))
         CMD_ADD: begin
            k_re = clip(ar + br);
            k_im = clip(ai + bi);
         end
         CMD_SUB: begin
            k_re = clip(de_re);
            k_im = clip(de_im);
         end
         CMD_NEG: begin
            k_re = clip(-ar);
            k_im = clip(-ai);
         end
         CMD_CONJ: begin
            k_re = clip(ar);
            k_im = clip(-ai);
         end
         CMD_EQUAL: begin
            ctl_in.eq = (de_re < tl) && (de_re > ntl) && (de_im < tl) && (de_im > ntl);
         end
         default: begin
         end
      endcase
      ctl_in.sat = k_re[W] | k_im[W];
   end

   // operand selection for the multiplier array
   always_comb begin
      xr_in  = mag(a_re);
      xi_in  = mag(a_im);
      yr_in  = mag(b_re);
      yi_in  = mag(b_im);
      sgn_in = '{xr: a_re[W-1], xi: a_im[W-1], yr: b_re[W-1], yi: b_im[W-1]};
      case (cmd_type'(cmd))
         CMD_RECIP: begin
            xr_in     = ONE;
            xi_in     = '0;
            sgn_in.xr = 1'b0;
            sgn_in.xi = 1'b0;
            yr_in     = mag(a_re);
            yi_in     = mag(a_im);
            sgn_in.yr = a_re[W-1];
            sgn_in.yi = a_im[W-1];
         end
         CMD_MOD: begin
            yr_in     = mag(a_re);
            yi_in     = mag(a_im);
            sgn_in.yr = a_re[W-1];
            sgn_in.yi = a_im[W-1];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff  <= k_re[W-1:0];
         im_ff  <= k_im[W-1:0];
         xr_ff  <= xr_in;
         xi_ff  <= xi_in;
         yr_ff  <= yr_in;
         yi_ff  <= yi_in;
         sgn_ff <= sgn_in;
      end
   end

   assign ctl  = ctl_ff;
   assign re   = re_ff;
   assign im   = im_ff;
   assign xr_m = xr_ff;
   assign xi_m = xi_ff;
   assign yr_m = yr_ff;
   assign yi_m = yi_ff;
   assign sgn  = sgn_ff;

endmodule

>>> hw/rtl/cau_prod.sv
// ----------------------------------------------------------------------------
// cau_prod
// Multiplier array and product sums over five stages: products, signing,
// sums, magnitudes, then multiply result and divider / root set-up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_prod #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  cau_pkg::ctl_type               ctl_i,
   input  logic signed [DATA_WIDTH-1:0]   re_i,
   input  logic signed [DATA_WIDTH-1:0]   im_i,
   input  logic [DATA_WIDTH-1:0]          xr_m,
   input  logic [DATA_WIDTH-1:0]          xi_m,
   input  logic [DATA_WIDTH-1:0]          yr_m,
   input  logic [DATA_WIDTH-1:0]          yi_m,
   input  cau_pkg::sgn_type               sgn,
   output cau_pkg::ctl_type               ctl_o,
   output logic signed [DATA_WIDTH-1:0]   re_o,
   output logic signed [DATA_WIDTH-1:0]   im_o,
   output logic [2*DATA_WIDTH-1:0]        den_o,
   output logic [2*DATA_WIDTH-1:0]        rre_o,
   output logic [DATA_WIDTH-1:0]          qre_o,
   output logic [2*DATA_WIDTH-1:0]        rim_o,
   output logic [DATA_WIDTH-1:0]          qim_o
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int SW = PW + 1;
   localparam int CW = 3 * W - FRAC_BITS;
   localparam logic [PW-1:0] HALF_P = {{(PW-1){1'b0}}, 1'b1} << (W - 1);
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   function automatic logic signed [SW-1:0] sx(input logic [PW-1:0] m, input logic n);
      logic signed [SW-1:0] v;
      v = signed'({1'b0, m});
      return n ? -v : v;
   endfunction

   // drop fraction bits of a product magnitude and clip; top bit flags clipping
   function automatic logic [W:0] mfin(input logic n, input logic [PW-1:0] m);
      logic [PW-1:0] sh, lim;
      logic [W-1:0]  lo;
      logic [W:0]    r;
      sh  = m >> FRAC_BITS;
      lim = n ? HALF_P : HALF_P - 1'b1;
      lo  = sh[W-1:0];
      if (sh > lim) begin
         r = {1'b1, (n ? SMIN : SMAX)};
      end else begin
         r = {1'b0, (n ? -lo : lo)};
      end
      return r;
   endfunction

   ctl_type ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff, ctl6_ff, ctl6_in;
   logic signed [W-1:0] re2_ff, re3_ff, re4_ff, re5_ff, re6_ff, re6_in;
   logic signed [W-1:0] im2_ff, im3_ff, im4_ff, im5_ff, im6_ff, im6_in;

   logic [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_dr_ff, p_di_ff;
   logic          n_rr_ff, n_ii_ff, n_ri_ff, n_ir_ff;
   logic signed [SW-1:0] s_rr_ff, s_ii_ff, s_ri_ff, s_ir_ff;
   logic signed [SW-1:0] mre4_ff, mim4_ff, dre4_ff, dim4_ff;
   logic [PW-1:0] den3_ff, den4_ff, den5_ff, den6_ff;
   logic [PW-1:0] mre5_ff, mim5_ff, dre5_ff, dim5_ff;
   logic          nmre5_ff, nmim5_ff, ndre5_ff, ndim5_ff;
   logic [PW-1:0] rre6_ff, rim6_ff;
   logic [W-1:0]  qre6_ff, qim6_ff;
   logic [W:0]    mf_re, mf_im;
   logic [CW-1:0] nx_re, nx_im, dx;

   // control words, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else if (adv) begin
         ctl2_ff <= ctl_i;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= ctl6_in;
      end
   end

   // stages two to five: products, signed products, sums, magnitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         re2_ff  <= re_i;
         im2_ff  <= im_i;
         p_rr_ff <= xr_m * yr_m;
         p_ii_ff <= xi_m * yi_m;
         p_ri_ff <= xr_m * yi_m;
         p_ir_ff <= xi_m * yr_m;
         p_dr_ff <= yr_m * yr_m;
         p_di_ff <= yi_m * yi_m;
         n_rr_ff <= sgn.xr ^ sgn.yr;
         n_ii_ff <= sgn.xi ^ sgn.yi;
         n_ri_ff <= sgn.xr ^ sgn.yi;
         n_ir_ff <= sgn.xi ^ sgn.yr;

         re3_ff  <= re2_ff;
         im3_ff  <= im2_ff;
         s_rr_ff <= sx(p_rr_ff, n_rr_ff);
         s_ii_ff <= sx(p_ii_ff, n_ii_ff);
         s_ri_ff <= sx(p_ri_ff, n_ri_ff);
         s_ir_ff <= sx(p_ir_ff, n_ir_ff);
         den3_ff <= p_dr_ff + p_di_ff;

         re4_ff  <= re3_ff;
         im4_ff  <= im3_ff;
         mre4_ff <= s_rr_ff - s_ii_ff;
         mim4_ff <= s_ri_ff + s_ir_ff;
         dre4_ff <= s_rr_ff + s_ii_ff;
         dim4_ff <= s_ir_ff - s_ri_ff;
         den4_ff <= den3_ff;

         re5_ff   <= re4_ff;
         im5_ff   <= im4_ff;
         nmre5_ff <= mre4_ff[SW-1];
         nmim5_ff <= mim4_ff[SW-1];
         ndre5_ff <= dre4_ff[SW-1];
         ndim5_ff <= dim4_ff[SW-1];
         mre5_ff  <= PW'(mre4_ff[SW-1] ? -mre4_ff : mre4_ff);
         mim5_ff  <= PW'(mim4_ff[SW-1] ? -mim4_ff : mim4_ff);
         dre5_ff  <= PW'(dre4_ff[SW-1] ? -dre4_ff : dre4_ff);
         dim5_ff  <= PW'(dim4_ff[SW-1] ? -dim4_ff : dim4_ff);
         den5_ff  <= den4_ff;
      end
   end

   // stage six: multiply result, quotient overflow check, divider start values
   assign mf_re = mfin(nmre5_ff, mre5_ff);
   assign mf_im = mfin(nmim5_ff, mim5_ff);
   assign nx_re = CW'(dre5_ff);
   assign nx_im = CW'(dim5_ff);
   assign dx    = CW'(den5_ff) << (W - FRAC_BITS);

   always_comb begin
      ctl6_in        = ctl5_ff;
      re6_in         = re5_ff;
      im6_in         = im5_ff;
      ctl6_in.dz     = (den5_ff == '0);
      ctl6_in.ovf_re = (nx_re >= dx);
      ctl6_in.ovf_im = (nx_im >= dx);
      ctl6_in.neg_re = ndre5_ff;
      ctl6_in.neg_im = ndim5_ff;
      if (ctl5_ff.cmd == CMD_MUL) begin
         re6_in      = mf_re[W-1:0];
         im6_in      = mf_im[W-1:0];
         ctl6_in.sat = mf_re[W] | mf_im[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re6_ff  <= re6_in;
         im6_ff  <= im6_in;
         den6_ff <= den5_ff;
         rre6_ff <= PW'(dre5_ff >> (W - FRAC_BITS));
         rim6_ff <= PW'(dim5_ff >> (W - FRAC_BITS));
         qre6_ff <= W'(dre5_ff << FRAC_BITS);
         qim6_ff <= W'(dim5_ff << FRAC_BITS);
      end
   end

   assign ctl_o = ctl6_ff;
   assign re_o  = re6_ff;
   assign im_o  = im6_ff;
   assign den_o = den6_ff;
   assign rre_o = rre6_ff;
   assign rim_o = rim6_ff;
   assign qre_o = qre6_ff;
   assign qim_o = qim6_ff;

endmodule

>>> hw/rtl/cau_step.sv
// ----------------------------------------------------------------------------
// cau_step
// One stage of the iterative array: a restoring divide step for each
// quotient component and a digit step of the integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_step #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  cau_pkg::ctl_type             ctl_i,
   input  logic signed [DATA_WIDTH-1:0] re_i,
   input  logic signed [DATA_WIDTH-1:0] im_i,
   input  logic [2*DATA_WIDTH-1:0]      den_i,
   input  logic [2*DATA_WIDTH-1:0]      rre_i,
   input  logic [DATA_WIDTH-1:0]        qre_i,
   input  logic [2*DATA_WIDTH-1:0]      rim_i,
   input  logic [DATA_WIDTH-1:0]        qim_i,
   input  logic [2*DATA_WIDTH-1:0]      sq_i,
   input  logic [DATA_WIDTH+1:0]        srem_i,
   input  logic [DATA_WIDTH-1:0]        root_i,
   output cau_pkg::ctl_type             ctl_o,
   output logic signed [DATA_WIDTH-1:0] re_o,
   output logic signed [DATA_WIDTH-1:0] im_o,
   output logic [2*DATA_WIDTH-1:0]      den_o,
   output logic [2*DATA_WIDTH-1:0]      rre_o,
   output logic [DATA_WIDTH-1:0]        qre_o,
   output logic [2*DATA_WIDTH-1:0]      rim_o,
   output logic [DATA_WIDTH-1:0]        qim_o,
   output logic [2*DATA_WIDTH-1:0]      sq_o,
   output logic [DATA_WIDTH+1:0]        srem_o,
   output logic [DATA_WIDTH-1:0]        root_o
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;

   // shift in the next dividend bit, subtract the divisor if it fits;
   // the quotient bit enters where the dividend bit left
   function automatic logic [PW+W-1:0] dstep(input logic [PW-1:0] r,
                                            input logic [W-1:0] q,
                                            input logic [PW-1:0] d);
      logic [PW:0]   t;
      logic          ge;
      logic [PW-1:0] rn;
      t  = {r, q[W-1]};
      ge = (t >= {1'b0, d});
      rn = ge ? PW'(t - {1'b0, d}) : PW'(t);
      return {rn, q[W-2:0], ge};
   endfunction

   ctl_type              ctl_ff;
   logic signed [W-1:0]  re_ff, im_ff;
   logic [PW-1:0]        den_ff, rre_ff, rim_ff, sq_ff;
   logic [W-1:0]         qre_ff, qim_ff, root_ff;
   logic [W+1:0]         srem_ff, srem_in;
   logic [PW+W-1:0]      dv_re, dv_im;
   logic [W+3:0]         st, trial;
   logic                 sge;

   assign dv_re = dstep(rre_i, qre_i, den_i);
   assign dv_im = dstep(rim_i, qim_i, den_i);

   // root digit: bring down two radicand bits, try root*4+1
   assign st      = {srem_i, sq_i[PW-1:PW-2]};
   assign trial   = {2'b00, root_i, 2'b01};
   assign sge     = (st >= trial);
   assign srem_in = sge ? (W+2)'(st - trial) : (W+2)'(st);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff   <= re_i;
         im_ff   <= im_i;
         den_ff  <= den_i;
         rre_ff  <= dv_re[PW+W-1:W];
         qre_ff  <= dv_re[W-1:0];
         rim_ff  <= dv_im[PW+W-1:W];
         qim_ff  <= dv_im[W-1:0];
         sq_ff   <= sq_i << 2;
         srem_ff <= srem_in;
         root_ff <= {root_i[W-2:0], sge};
      end
   end

   assign ctl_o  = ctl_ff;
   assign re_o   = re_ff;
   assign im_o   = im_ff;
   assign den_o  = den_ff;
   assign rre_o  = rre_ff;
   assign qre_o  = qre_ff;
   assign rim_o  = rim_ff;
   assign qim_o  = qim_ff;
   assign sq_o   = sq_ff;
   assign srem_o = srem_ff;
   assign root_o = root_ff;

endmodule

>>> hw/rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex ALU in signed fixed point (Q16.16 by default): add, sub, mul, div,
// neg, conj, reciprocal, modulus and equality with a tolerance register.
//
// Requests enter on req_ch and results leave on rsp_ch, both valid/ready;
// a transfer happens on a clock edge where valid and ready are both high.
// Every request gives exactly one response, in order.
// The pipeline takes one transfer per cycle while the output register is free
// or being taken. It has one operand stage, five multiplier and sum
// stages, one stage per quotient / root bit in the divide and square root
// array, and the output register.
// When the receiver stalls on a full output register the whole pipeline holds
// and req_ch.ready drops until it is taken; nothing is lost or repeated.
// csr_we writes csr_wdata into the equality tolerance; write it only while
// the pipeline is empty. Reset (synchronous) empties the pipeline and sets
// the tolerance to one LSB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   cau_req_if.sink                    req_ch,
   cau_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [cau_pkg::TOL_W-1:0]  csr_wdata
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] HALF_W = {1'b1, {(W-1){1'b0}}};

   // sign a quotient magnitude and clip; top bit flags clipping
   function automatic logic [W:0] dfin(input logic [W-1:0] q, input logic n,
                                       input logic ovf);
      logic [W:0] r;
      if (ovf || (n ? (q > HALF_W) : (q > HALF_W - 1'b1))) begin
         r = {1'b1, (n ? SMIN : SMAX)};
      end else begin
         r = {1'b0, (n ? -q : q)};
      end
      return r;
   endfunction

   logic                 adv;
   logic [TOL_W-1:0]     tol_ff;
   ctl_type              f_ctl;
   logic signed [W-1:0]  f_re, f_im;
   logic [W-1:0]         f_xr, f_xi, f_yr, f_yi;
   sgn_type              f_sgn;

   ctl_type              ctl_w  [0:W];
   logic signed [W-1:0]  re_w   [0:W];
   logic signed [W-1:0]  im_w   [0:W];
   logic [PW-1:0]        den_w  [0:W];
   logic [PW-1:0]        rre_w  [0:W];
   logic [W-1:0]         qre_w  [0:W];
   logic [PW-1:0]        rim_w  [0:W];
   logic [W-1:0]         qim_w  [0:W];
   logic [PW-1:0]        sq_w   [0:W];
   logic [W+1:0]         srem_w [0:W];
   logic [W-1:0]         root_w [0:W];

   ctl_type              lc;
   logic [W:0]           qf_re, qf_im;
   logic signed [W-1:0]  res_re_in, res_im_in, res_re_ff, res_im_ff;
   logic                 sat_in, dz_in, sat_ff, dz_ff, eq_ff;
   logic                 vld_ff;

   // global advance: the output register is free or being taken
   assign adv          = !vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .in_vld (req_ch.valid),
      .cmd    (req_ch.cmd),
      .a_re   (req_ch.a_re),
      .a_im   (req_ch.a_im),
      .b_re   (req_ch.b_re),
      .b_im   (req_ch.b_im),
      .tol    (tol_ff),
      .ctl    (f_ctl),
      .re     (f_re),
      .im     (f_im),
      .xr_m   (f_xr),
      .xi_m   (f_xi),
      .yr_m   (f_yr),
      .yi_m   (f_yi),
      .sgn    (f_sgn)
   );

   cau_prod #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_prod (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .ctl_i (f_ctl),
      .re_i  (f_re),
      .im_i  (f_im),
      .xr_m  (f_xr),
      .xi_m  (f_xi),
      .yr_m  (f_yr),
      .yi_m  (f_yi),
      .sgn   (f_sgn),
      .ctl_o (ctl_w[0]),
      .re_o  (re_w[0]),
      .im_o  (im_w[0]),
      .den_o (den_w[0]),
      .rre_o (rre_w[0]),
      .qre_o (qre_w[0]),
      .rim_o (rim_w[0]),
      .qim_o (qim_w[0])
   );

   // the radicand of modulus is the divisor slot; root starts empty
   assign sq_w[0]   = den_w[0];
   assign srem_w[0] = '0;
   assign root_w[0] = '0;

   // one bit of each quotient and one root bit per stage
   for (genvar i = 0; i < W; i++) begin : g_step
      cau_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_i  (ctl_w[i]),
         .re_i   (re_w[i]),
         .im_i   (im_w[i]),
         .den_i  (den_w[i]),
         .rre_i  (rre_w[i]),
         .qre_i  (qre_w[i]),
         .rim_i  (rim_w[i]),
         .qim_i  (qim_w[i]),
         .sq_i   (sq_w[i]),
         .srem_i (srem_w[i]),
         .root_i (root_w[i]),
         .ctl_o  (ctl_w[i+1]),
         .re_o   (re_w[i+1]),
         .im_o   (im_w[i+1]),
         .den_o  (den_w[i+1]),
         .rre_o  (rre_w[i+1]),
         .qre_o  (qre_w[i+1]),
         .rim_o  (rim_w[i+1]),
         .qim_o  (qim_w[i+1]),
         .sq_o   (sq_w[i+1]),
         .srem_o (srem_w[i+1]),
         .root_o (root_w[i+1])
      );
   end

   // final result selection
   assign lc    = ctl_w[W];
   assign qf_re = dfin(qre_w[W], lc.neg_re, lc.ovf_re);
   assign qf_im = dfin(qim_w[W], lc.neg_im, lc.ovf_im);

   always_comb begin
      res_re_in = re_w[W];
      res_im_in = im_w[W];
      sat_in    = lc.sat;
      dz_in     = 1'b0;
      case (lc.cmd)
         CMD_DIV, CMD_RECIP: begin
            if (lc.dz) begin
               res_re_in = '0;
               res_im_in = '0;
               sat_in    = 1'b0;
               dz_in     = 1'b1;
            end else begin
               res_re_in = qf_re[W-1:0];
               res_im_in = qf_im[W-1:0];
               sat_in    = qf_re[W] | qf_im[W];
            end
         end
         CMD_MOD: begin
            sat_in    = (root_w[W] > SMAX);
            res_re_in = sat_in ? SMAX : root_w[W];
            res_im_in = '0;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= lc.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         sat_ff    <= sat_in;
         dz_ff     <= dz_in;
         eq_ff     <= lc.eq;
      end
   end

   assign rsp_ch.valid     = vld_ff;
   assign rsp_ch.res_re    = res_re_ff;
   assign rsp_ch.res_im    = res_im_ff;
   assign rsp_ch.saturated = sat_ff;
   assign rsp_ch.div_zero  = dz_ff;
   assign rsp_ch.is_equal  = eq_ff;

endmodule

>>> dv/complex_arithmetic_unit_test.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_test
// Self-checking bench for the complex arithmetic unit. A clocked driver sends
// requests from a queue with random gaps. A clocked monitor accepts responses
// with random stalls (both off in one phase), and once with a long hold-off.
// Each response is checked field by field against a bit-exact predictor of
// the Q16.16 datapath. The run covers several tolerances, up to the largest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;
   import cau_pkg::*;

   localparam int DW       = DATA_WIDTH_DEF;
   localparam int FB       = FRAC_BITS_DEF;
   localparam int LATENCY  = DW + 7;
   localparam int N_RANDOM = 440;      // random requests per tolerance phase
   localparam int WD_LIMIT = 3000;     // cycles without any transfer

   typedef logic signed [191:0] acc_type;
   localparam acc_type Q_MAX = acc_type'(32'sh7fff_ffff);
   localparam acc_type Q_MIN = acc_type'(32'sh8000_0000);
   localparam logic signed [DW-1:0] W_MAX = 32'sh7fff_ffff;
   localparam logic signed [DW-1:0] W_MIN = 32'sh8000_0000;
   localparam logic signed [DW-1:0] W_ONE = 32'sh0001_0000;

   typedef struct {
      logic [CMD_W-1:0]      cmd;
      logic signed [DW-1:0]  a_re, a_im, b_re, b_im;
   } request_type;

   typedef struct {
      logic signed [DW-1:0]  re, im;
      logic                  eq, dz, sat;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [TOL_W-1:0] csr_wdata = '0;

   cau_req_if #(.DATA_WIDTH(DW)) req_ch ();
   cau_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   request_type  pending_reqs[$];
   outcome_type  awaited[$];
   logic [TOL_W-1:0] tolerance = TOL_RESET;
   bit           gaps_on = 1'b1;
   bit           hold_wanted = 1'b0;
   int           mismatches = 0;
   int           sent = 0;
   int           received = 0;
   int           cmd_seen[16];

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic logic signed [DW-1:0] clip(input acc_type v, inout logic sat);
      if (v > Q_MAX) begin
         sat = 1'b1;
         return W_MAX;
      end
      if (v < Q_MIN) begin
         sat = 1'b1;
         return W_MIN;
      end
      return v[DW-1:0];
   endfunction

   // truncated toward zero: magnitude scaled by 2^FB, then divided
   function automatic acc_type frac_quotient(input acc_type n, input acc_type den);
      acc_type mag;
      mag = (n < 0) ? -n : n;
      mag = (mag <<< FB) / den;
      return (n < 0) ? -mag : mag;
   endfunction

   function automatic void complex_divide(input acc_type xr, xi, yr, yi,
                                          inout outcome_type r);
      acc_type den, nre, nim;
      den = yr * yr + yi * yi;
      if (den == 0) begin
         r.dz = 1'b1;
         return;
      end
      nre = xr * yr + xi * yi;
      nim = xi * yr - xr * yi;
      r.re = clip(frac_quotient(nre, den), r.sat);
      r.im = clip(frac_quotient(nim, den), r.sat);
   endfunction

   function automatic acc_type drop_frac(input acc_type v);
      return (v < 0) ? -((-v) >>> FB) : (v >>> FB);
   endfunction

   function automatic outcome_type predict_result(input request_type q,
                                                  input logic [TOL_W-1:0] tol);
      outcome_type r;
      acc_type ar, ai, br, bi, sq, dr, di;
      logic [63:0] root, cand;
      r = '{re: '0, im: '0, eq: 1'b0, dz: 1'b0, sat: 1'b0};
      ar = acc_type'(q.a_re);
      ai = acc_type'(q.a_im);
      br = acc_type'(q.b_re);
      bi = acc_type'(q.b_im);
      case (q.cmd)
         CMD_ADD: begin
            r.re = clip(ar + br, r.sat);
            r.im = clip(ai + bi, r.sat);
         end
         CMD_SUB: begin
            r.re = clip(ar - br, r.sat);
            r.im = clip(ai - bi, r.sat);
         end
         CMD_MUL: begin
            r.re = clip(drop_frac(ar * br - ai * bi), r.sat);
            r.im = clip(drop_frac(ar * bi + ai * br), r.sat);
         end
         CMD_DIV:   complex_divide(ar, ai, br, bi, r);
         CMD_RECIP: complex_divide(acc_type'(W_ONE), 0, ar, ai, r);
         CMD_NEG: begin
            r.re = clip(-ar, r.sat);
            r.im = clip(-ai, r.sat);
         end
         CMD_CONJ: begin
            r.re = clip(ar, r.sat);
            r.im = clip(-ai, r.sat);
         end
         CMD_MOD: begin
            sq = ar * ar + ai * ai;
            root = '0;
            for (int b = 32; b >= 0; b--) begin
               cand = root | (64'd1 << b);
               if (acc_type'(cand) * acc_type'(cand) <= sq) root = cand;
            end
            r.re = clip(acc_type'(root), r.sat);
         end
         CMD_EQUAL: begin
            dr = ar - br;
            di = ai - bi;
            if (dr < 0) dr = -dr;
            if (di < 0) di = -di;
            r.eq = (dr < acc_type'(tol)) && (di < acc_type'(tol));
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic signed [DW-1:0] pick_operand();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2: return DW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         3, 4, 5: return $urandom;
         6: begin
            case ($urandom_range(0, 4))
               0: return W_MIN;
               1: return W_MAX;
               2: return W_ONE;
               3: return -1;
               default: return 0;
            endcase
         end
         7, 8: return DW'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
         default: return 0;
      endcase
   endfunction

   function automatic request_type random_request();
      request_type q;
      int r;
      r = $urandom_range(0, 99);
      q.cmd = (r < 96) ? CMD_W'(r % 9) : CMD_W'($urandom_range(CMD_EQUAL + 1, 15));
      q.a_re = pick_operand();
      q.a_im = pick_operand();
      q.b_re = pick_operand();
      q.b_im = pick_operand();
      // near-equal operands so the tolerance is exercised on both sides
      if (q.cmd == CMD_EQUAL && $urandom_range(0, 1)) begin
         q.b_re = q.a_re + DW'($signed($urandom_range(0, 2 * tolerance + 2)) - tolerance - 1);
         q.b_im = q.a_im + DW'($signed($urandom_range(0, 2 * tolerance + 2)) - tolerance - 1);
      end
      if (q.cmd == CMD_DIV && $urandom_range(0, 15) == 0) begin
         q.b_re = 0;
         q.b_im = 0;
      end
      if (q.cmd == CMD_RECIP && $urandom_range(0, 15) == 0) begin
         q.a_re = 0;
         q.a_im = 0;
      end
      return q;
   endfunction

   task automatic add_req(input cmd_type c, input logic signed [DW-1:0] ar, ai, br, bi);
      pending_reqs.push_back('{cmd: c, a_re: ar, a_im: ai, b_re: br, b_im: bi});
   endtask

   task automatic drain_pipeline();
      while (pending_reqs.size() != 0 || awaited.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic set_tolerance(input logic [TOL_W-1:0] value);
      drain_pipeline();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tolerance = value;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------
   initial begin
      logic [TOL_W-1:0] tol_plan[4];
      tol_plan = '{TOL_RESET, 16'hffff, 16'd0, 16'd1};
      tol_plan[2] = TOL_W'($urandom_range(2, 4000));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every command, zero divisors, clipping
      add_req(CMD_ADD,   W_MAX, W_MIN, W_MAX, W_MIN);
      add_req(CMD_ADD,   W_MIN, W_MAX, 1, -1);
      add_req(CMD_SUB,   W_MIN, W_MAX, 1, -1);
      add_req(CMD_SUB,   0, 0, W_MIN, W_MIN);
      add_req(CMD_MUL,   W_MAX, W_MAX, W_MAX, W_MIN);
      add_req(CMD_MUL,   W_ONE, -W_ONE, -W_ONE, W_ONE);
      add_req(CMD_MUL,   -3, 5, 7, -11);
      add_req(CMD_DIV,   W_ONE, W_ONE, 0, 0);
      add_req(CMD_DIV,   W_MAX, W_MIN, 1, 0);
      add_req(CMD_DIV,   W_MAX, 1, W_MAX, W_MIN);
      add_req(CMD_DIV,   -7, 3, 2, -1);
      add_req(CMD_NEG,   W_MIN, W_MAX, 0, 0);
      add_req(CMD_CONJ,  W_MIN, W_MIN, 0, 0);
      add_req(CMD_CONJ,  W_MAX, W_MAX, 0, 0);
      add_req(CMD_RECIP, 0, 0, W_ONE, W_ONE);
      add_req(CMD_RECIP, 1, 0, 0, 0);
      add_req(CMD_RECIP, W_MIN, W_MIN, 0, 0);
      add_req(CMD_RECIP, -W_ONE, W_ONE, 0, 0);
      add_req(CMD_MOD,   W_MIN, W_MIN, 0, 0);
      add_req(CMD_MOD,   3 << FB, -(4 << FB), 0, 0);
      add_req(CMD_MOD,   0, 0, W_MAX, W_MAX);
      add_req(CMD_EQUAL, W_MAX, W_MIN, W_MAX, W_MIN);
      add_req(CMD_EQUAL, 0, 0, 1, 0);
      add_req(CMD_EQUAL, W_MIN, W_MAX, W_MAX, W_MIN);
      pending_reqs.push_back('{cmd: 4'hf, a_re: W_MAX, a_im: W_MIN, b_re: -1, b_im: 1});

      foreach (tol_plan[p]) begin
         if (p != 0) set_tolerance(tol_plan[p]);
         gaps_on = (p != 2);
         if (p == 1) hold_wanted = 1'b1;
         for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(random_request());
         drain_pipeline();
      end

      $display("Sent %0d requests, received %0d results over four tolerances (%0d .. %0d).",
               sent, received, TOL_RESET, 16'hffff);
      $display("Commands seen: add %0d sub %0d mul %0d div %0d neg %0d conj %0d",
               cmd_seen[CMD_ADD], cmd_seen[CMD_SUB], cmd_seen[CMD_MUL],
               cmd_seen[CMD_DIV], cmd_seen[CMD_NEG], cmd_seen[CMD_CONJ]);
      if (mismatches == 0 && awaited.size() == 0) begin
         $display("complex_arithmetic_unit_test: clean");
      end else begin
         $display("complex_arithmetic_unit_test: errors");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: one request per transfer, optional random gaps between offers
   // ---------------------------------------------------------------------
   request_type on_bus;
   int          gap_left = 0;

   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.cmd   <= '0;
         req_ch.a_re  <= '0;
         req_ch.a_im  <= '0;
         req_ch.b_re  <= '0;
         req_ch.b_im  <= '0;
      end else begin
         next_valid = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            awaited.push_back(predict_result(on_bus, tolerance));
            cmd_seen[on_bus.cmd]++;
            sent++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() != 0) begin
               on_bus = pending_reqs.pop_front();
               req_ch.cmd  <= on_bus.cmd;
               req_ch.a_re <= on_bus.a_re;
               req_ch.a_im <= on_bus.a_im;
               req_ch.b_re <= on_bus.b_re;
               req_ch.b_im <= on_bus.b_im;
               next_valid = 1'b1;
               gap_left = gaps_on ? $urandom_range(0, 7) : 0;
            end
         end
         req_ch.valid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: optional random stalls, one long hold-off, in-order compare
   // ---------------------------------------------------------------------
   int  stall_left = 0;
   bit  hold_done  = 1'b0;

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            received++;
            if (awaited.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: unexpected result re=%h im=%h", $realtime,
                           rsp_ch.res_re, rsp_ch.res_im);
            end else begin
               want = awaited.pop_front();
               if (rsp_ch.res_re !== want.re || rsp_ch.res_im !== want.im ||
                   rsp_ch.is_equal !== want.eq || rsp_ch.div_zero !== want.dz ||
                   rsp_ch.saturated !== want.sat) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%t: result %0d expected re=%h im=%h eq=%b dz=%b sat=%b,",
                               " got re=%h im=%h eq=%b dz=%b sat=%b"},
                              $realtime, received, want.re, want.im, want.eq, want.dz,
                              want.sat, rsp_ch.res_re, rsp_ch.res_im, rsp_ch.is_equal,
                              rsp_ch.div_zero, rsp_ch.saturated);
               end
            end
            // wait before taking the next result
            if (gaps_on) stall_left = $urandom_range(0, 7);
         end
         if (hold_wanted && !hold_done && sent > 0) begin
            hold_done = 1'b1;
            stall_left = 400;                  // long enough to back up the pipeline
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog on cycles without any transfer
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", WD_LIMIT);
         $display("complex_arithmetic_unit_test: errors");
         $finish;
      end
   end

endmodule

>>> filelist.f
hw/rtl/cau_pkg.sv
hw/rtl/cau_req_if.sv
hw/rtl/cau_rsp_if.sv
hw/rtl/cau_front.sv
hw/rtl/cau_prod.sv
hw/rtl/cau_step.sv
hw/rtl/complex_arithmetic_unit.sv
dv/complex_arithmetic_unit_test.sv
